// File: hdl/scaled_glyph_text_cursor_assert.svh
// Assertion macros for the scaled glyph text cursor.
// Both expect clk and rst_n to be visible where they are used.
`ifndef SCALED_GLYPH_TEXT_CURSOR_ASSERT_SVH
`define SCALED_GLYPH_TEXT_CURSOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SGTC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgtc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SGTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgtc: next-cycle check failed");

`endif

// File: hdl/sgtc_pkg.sv
package sgtc_pkg;

  // Glyph geometry
  localparam int GLYPH_COLS    = 6;
  localparam int SCALE         = 2;
  localparam int GLYPH_ROWS    = 8;
  localparam int GLYPH_COUNT   = 128;

  localparam int FONT_DEPTH    = GLYPH_COUNT * GLYPH_COLS;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int CELL_W        = GLYPH_COLS * SCALE;
  localparam int CELL_H        = GLYPH_ROWS * SCALE;
  localparam int BYTES_PER_COL = SCALE * SCALE;
  localparam int BITS_PER_BYTE = GLYPH_ROWS / SCALE;
  localparam int COL_IW        = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
  localparam int BYTE_IW       = (BYTES_PER_COL > 1) ? $clog2(BYTES_PER_COL) : 1;

  // Register map
  localparam int NUM_REGS = 5;
  localparam int CFG_AW   = $clog2(4 * NUM_REGS);
  localparam int REG_IW   = CFG_AW - 2;

  localparam logic [REG_IW-1:0] REG_AREA_LEFT   = REG_IW'(0);
  localparam logic [REG_IW-1:0] REG_AREA_TOP    = REG_IW'(1);
  localparam logic [REG_IW-1:0] REG_AREA_RIGHT  = REG_IW'(2);
  localparam logic [REG_IW-1:0] REG_AREA_BOTTOM = REG_IW'(3);
  localparam logic [REG_IW-1:0] REG_FILL_COLOR  = REG_IW'(4);

  localparam logic [7:0]  AREA_LEFT_RST   = 8'd0;
  localparam logic [7:0]  AREA_TOP_RST    = 8'd0;
  localparam logic [7:0]  AREA_RIGHT_RST  = 8'd127;
  localparam logic [7:0]  AREA_BOTTOM_RST = 8'd63;
  localparam logic [15:0] FILL_COLOR_RST  = 16'd0;

  // Input operations
  localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [2:0] OP_SET_CURSOR = 3'd1;
  localparam logic [2:0] OP_SAVE       = 3'd2;
  localparam logic [2:0] OP_RESTORE    = 3'd3;
  localparam logic [2:0] OP_FONT_WR    = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_WINDOW = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  typedef struct packed {
    logic [7:0]  area_left;
    logic [7:0]  area_top;
    logic [7:0]  area_right;
    logic [7:0]  area_bottom;
    logic [15:0] fill_color;
    logic        home;      // an area register is being written
    logic [7:0]  home_x;    // area_left as it stands after that write
    logic [7:0]  home_y;    // area_top as it stands after that write
  } cfg_t;

  // Clamp a coordinate to the 8-bit screen range
  function automatic logic [7:0] sat8(logic [9:0] v);
    sat8 = (v > 10'd255) ? 8'd255 : v[7:0];
  endfunction

  // Build one display byte of a column: each font bit repeated SCALE times,
  // bit 0 top, idx runs over the SCALE*SCALE bytes of the column
  function automatic logic [7:0] expand_byte(logic [7:0] col, logic [BYTE_IW-1:0] idx);
    logic [7:0] res;
    int         grp;
    int         src;
    grp = int'(idx) % SCALE;
    for (int d = 0; d < 8; d++) begin
      src    = grp * BITS_PER_BYTE + d / SCALE;
      res[d] = col[src];
    end
    return res;
  endfunction

endpackage

// File: hdl/sgtc_chan_if.sv
interface sgtc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [6:0] char_code;
  logic [7:0] text_col;
  logic [7:0] text_row;
  logic [7:0] font_byte;

  modport source (output valid, op, char_code, text_col, text_row, font_byte,
                  input ready);
  modport sink (input valid, op, char_code, text_col, text_row, font_byte,
                output ready);
endinterface

interface sgtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  rect_left;
  logic [7:0]  rect_top;
  logic [7:0]  rect_right;
  logic [7:0]  rect_bottom;
  logic [15:0] color;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, kind, rect_left, rect_top, rect_right, rect_bottom,
                  color, data_byte, last, input ready);
  modport sink (input valid, kind, rect_left, rect_top, rect_right, rect_bottom,
                color, data_byte, last, output ready);
endinterface

// File: hdl/sgtc_regs.sv
module sgtc_regs import sgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [7:0]        area_left_r;
  logic [7:0]        area_top_r;
  logic [7:0]        area_right_r;
  logic [7:0]        area_bottom_r;
  logic [15:0]       fill_color_r;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;
  logic              area_wr;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign area_wr = wr_en && (reg_idx == REG_AREA_LEFT || reg_idx == REG_AREA_TOP ||
                             reg_idx == REG_AREA_RIGHT || reg_idx == REG_AREA_BOTTOM);

  // Take register writes in the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_left_r   <= AREA_LEFT_RST;
      area_top_r    <= AREA_TOP_RST;
      area_right_r  <= AREA_RIGHT_RST;
      area_bottom_r <= AREA_BOTTOM_RST;
      fill_color_r  <= FILL_COLOR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AREA_LEFT:   area_left_r   <= pwdata[7:0];
        REG_AREA_TOP:    area_top_r    <= pwdata[7:0];
        REG_AREA_RIGHT:  area_right_r  <= pwdata[7:0];
        REG_AREA_BOTTOM: area_bottom_r <= pwdata[7:0];
        REG_FILL_COLOR:  fill_color_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_AREA_LEFT:   prdata = {24'd0, area_left_r};
      REG_AREA_TOP:    prdata = {24'd0, area_top_r};
      REG_AREA_RIGHT:  prdata = {24'd0, area_right_r};
      REG_AREA_BOTTOM: prdata = {24'd0, area_bottom_r};
      REG_FILL_COLOR:  prdata = {16'd0, fill_color_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Home position carries the value being written so the cursors see it at once
  always_comb begin
    cfg.area_left   = area_left_r;
    cfg.area_top    = area_top_r;
    cfg.area_right  = area_right_r;
    cfg.area_bottom = area_bottom_r;
    cfg.fill_color  = fill_color_r;
    cfg.home        = area_wr;
    cfg.home_x      = (wr_en && reg_idx == REG_AREA_LEFT) ? pwdata[7:0] : area_left_r;
    cfg.home_y      = (wr_en && reg_idx == REG_AREA_TOP) ? pwdata[7:0] : area_top_r;
  end

endmodule

// File: hdl/sgtc_font_ram.sv
module sgtc_font_ram #(
  parameter int DEPTH = 768,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sgtc_render.sv
module sgtc_render import sgtc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  sgtc_in_if.sink            in_ch,
  sgtc_out_if.source         out_ch,
  output logic               font_we,
  output logic [FONT_AW-1:0] font_waddr,
  output logic [7:0]         font_wdata,
  output logic               font_re,
  output logic [FONT_AW-1:0] font_raddr,
  input  logic [7:0]         font_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_FILL = 5'b00100,
    S_WIN  = 5'b01000,
    S_DATA = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [7:0]           cur_x_r, cur_y_r, sav_x_r, sav_y_r;
  logic [7:0]           win_l_r, win_t_r, win_r_r, win_b_r;
  logic [FONT_AW-1:0]   base_r;
  logic                 glyph_ok_r;
  logic [COL_IW-1:0]    col_r;
  logic [BYTE_IW-1:0]   byte_r;

  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [7:0]           out_l_r, out_t_r, out_rt_r, out_b_r, out_data_r;
  logic [15:0]          out_color_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 can_load;
  logic                 beat_go;
  logic                 col_last, byte_last;
  logic [FONT_AW-1:0]   code_base;
  logic                 code_ok;

  // Line-feed and window arithmetic
  logic [8:0]           end_x0;
  logic                 lf;
  logic [7:0]           cx;
  logic [8:0]           cy9;
  logic [9:0]           ey10;
  logic                 wrap;
  logic [7:0]           cy_fin;
  logic [8:0]           ex, ey_fin;

  // Set-cursor arithmetic
  logic [15:0]          px, py;

  // Beat being loaded into the output register
  logic [1:0]           b_kind;
  logic [7:0]           b_l, b_t, b_rt, b_b, b_data;
  logic [15:0]          b_color;
  logic                 b_last;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid_r || out_ch.ready;
  assign beat_go     = can_load && (state_r == S_FILL || state_r == S_WIN || state_r == S_DATA);
  assign col_last    = (col_r == COL_IW'(GLYPH_COLS - 1));
  assign byte_last   = (byte_r == BYTE_IW'(BYTES_PER_COL - 1));
  assign code_base   = FONT_AW'(in_ch.char_code) * FONT_AW'(GLYPH_COLS);
  assign code_ok     = int'(in_ch.char_code) < GLYPH_COUNT;

  // Advance or wrap the cursor for the glyph about to be drawn
  always_comb begin
    end_x0 = {1'b0, cur_x_r} + 9'(CELL_W);
    lf     = end_x0 > {1'b0, cfg.area_right};
    cx     = lf ? cfg.area_left : cur_x_r;
    cy9    = lf ? ({1'b0, cur_y_r} + 9'(CELL_H)) : {1'b0, cur_y_r};
    ey10   = {1'b0, cy9} + 10'(CELL_H);
    wrap   = lf && (ey10 > {2'b00, cfg.area_bottom});
    cy_fin = wrap ? cfg.area_top : cy9[7:0];
    ex     = {1'b0, cx} + 9'(CELL_W);
    ey_fin = {1'b0, cy_fin} + 9'(CELL_H);
  end

  // Text position to pixel position
  assign px = 16'(cfg.area_left) + 16'(in_ch.text_col) * 16'(CELL_W);
  assign py = 16'(cfg.area_top) + 16'(in_ch.text_row) * 16'(CELL_H);

  // Font store access: write on a font load, read a column ahead of its data words
  always_comb begin
    font_we    = in_acc && in_ch.op == OP_FONT_WR && code_ok &&
                 int'(in_ch.text_col) < GLYPH_COLS;
    font_waddr = code_base + FONT_AW'(in_ch.text_col);
    font_wdata = in_ch.font_byte;
    font_re    = 1'b0;
    font_raddr = code_base;
    if (in_acc && in_ch.op == OP_PUT_CHAR) begin
      font_re = 1'b1;
    end else if (state_r == S_DATA && beat_go && byte_last && !col_last) begin
      font_re    = 1'b1;
      font_raddr = base_r + FONT_AW'(col_r) + FONT_AW'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_ch.op == OP_PUT_CHAR) state_nxt = S_PREP;
      S_PREP: state_nxt = lf ? S_FILL : S_WIN;
      S_FILL: if (beat_go) state_nxt = S_WIN;
      S_WIN:  if (beat_go) state_nxt = S_DATA;
      S_DATA: if (beat_go && byte_last && col_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Cursor and saved cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= AREA_LEFT_RST;
      cur_y_r <= AREA_TOP_RST;
      sav_x_r <= AREA_LEFT_RST;
      sav_y_r <= AREA_TOP_RST;
    end else if (cfg.home) begin
      cur_x_r <= cfg.home_x;
      cur_y_r <= cfg.home_y;
      sav_x_r <= cfg.home_x;
      sav_y_r <= cfg.home_y;
    end else if (state_r == S_PREP) begin
      cur_x_r <= sat8({1'b0, ex});
      cur_y_r <= cy_fin;
    end else if (in_acc) begin
      case (in_ch.op)
        OP_SET_CURSOR: begin
          cur_x_r <= (px > 16'(cfg.area_right)) ? cfg.area_left : px[7:0];
          cur_y_r <= (py > 16'(cfg.area_bottom)) ? cfg.area_top : py[7:0];
        end
        OP_SAVE: begin
          sav_x_r <= cur_x_r;
          sav_y_r <= cur_y_r;
        end
        OP_RESTORE: begin
          cur_x_r <= sav_x_r;
          cur_y_r <= sav_y_r;
        end
        default: ;
      endcase
    end
  end

  // Glyph context and word counters
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.op == OP_PUT_CHAR) begin
      base_r     <= code_base;
      glyph_ok_r <= code_ok;
    end
    if (state_r == S_PREP) begin
      win_l_r <= cx;
      win_t_r <= cy_fin;
      win_r_r <= sat8({1'b0, ex});
      win_b_r <= sat8({1'b0, ey_fin});
    end
    if (state_r == S_WIN) begin
      col_r  <= '0;
      byte_r <= '0;
    end else if (state_r == S_DATA && beat_go) begin
      if (byte_last) begin
        byte_r <= '0;
        col_r  <= col_r + COL_IW'(1);
      end else begin
        byte_r <= byte_r + BYTE_IW'(1);
      end
    end
  end

  // Select the word to present
  always_comb begin
    b_kind  = KIND_DATA;
    b_l     = 8'd0;
    b_t     = 8'd0;
    b_rt    = 8'd0;
    b_b     = 8'd0;
    b_color = 16'd0;
    b_data  = 8'd0;
    b_last  = 1'b0;
    case (state_r)
      S_FILL: begin
        b_kind  = KIND_FILL;
        b_l     = cfg.area_left;
        b_t     = win_t_r;
        b_rt    = cfg.area_right;
        b_b     = win_b_r;
        b_color = cfg.fill_color;
      end
      S_WIN: begin
        b_kind = KIND_WINDOW;
        b_l    = win_l_r;
        b_t    = win_t_r;
        b_rt   = win_r_r;
        b_b    = win_b_r;
      end
      S_DATA: begin
        b_data = glyph_ok_r ? expand_byte(font_rdata, byte_r) : 8'd0;
        b_last = byte_last && col_last;
      end
      default: ;
    endcase
  end

  // Output register: load a new word when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_go) begin
      out_kind_r  <= b_kind;
      out_l_r     <= b_l;
      out_t_r     <= b_t;
      out_rt_r    <= b_rt;
      out_b_r     <= b_b;
      out_color_r <= b_color;
      out_data_r  <= b_data;
      out_last_r  <= b_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.rect_left   = out_l_r;
  assign out_ch.rect_top    = out_t_r;
  assign out_ch.rect_right  = out_rt_r;
  assign out_ch.rect_bottom = out_b_r;
  assign out_ch.color       = out_color_r;
  assign out_ch.data_byte   = out_data_r;
  assign out_ch.last        = out_last_r;

endmodule

// File: hdl/scaled_glyph_text_cursor.sv
// Text renderer for a page-organised monochrome display.
// in_ch carries one command word per handshake: put char, set cursor, save
// cursor, restore cursor or font load. out_ch carries the display words of a
// put char: an optional fill of the new text line, the address window, then
// GLYPH_COLS*SCALE*SCALE pixel bytes, with last set on the final word.
// Set, save, restore and font load produce no word and leave in_ch.ready high.
// A put char holds in_ch.ready low from its acceptance until its last word
// is loaded into the output register: the S_PREP state works out the cursor
// advance, then one word per cycle while out_ch is ready, 25 or 26 words with
// the default geometry. The first word comes from S_FILL or S_WIN, which
// follow S_PREP. The glyph columns come from a single-port-read font store
// with a registered read, each column fetched while the previous column's
// bytes are going out.
// A stall on out_ch holds the current word and pauses the sequence.
// Reset clears cursors and area registers to their defaults; the font store
// is not cleared and must be loaded before use. Area writes on the register
// port move both cursors to the area origin.
module scaled_glyph_text_cursor import sgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sgtc_in_if.sink           in_ch,
  sgtc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t               cfg;
  logic               font_we;
  logic [FONT_AW-1:0] font_waddr;
  logic [7:0]         font_wdata;
  logic               font_re;
  logic [FONT_AW-1:0] font_raddr;
  logic [7:0]         font_rdata;

  sgtc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgtc_font_ram #(
    .DEPTH (FONT_DEPTH),
    .WIDTH (8)
  ) u_font_ram (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (font_wdata),
    .re    (font_re),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  sgtc_render u_render (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .font_we    (font_we),
    .font_waddr (font_waddr),
    .font_wdata (font_wdata),
    .font_re    (font_re),
    .font_raddr (font_raddr),
    .font_rdata (font_rdata)
  );

endmodule

// File: hdl/sgtc_checker.sv
`include "scaled_glyph_text_cursor_assert.svh"

module sgtc_checker import sgtc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_rect_left,
  input logic [7:0]  out_rect_top,
  input logic [7:0]  out_rect_right,
  input logic [7:0]  out_rect_bottom,
  input logic [15:0] out_color,
  input logic [7:0]  out_data_byte,
  input logic        out_last
);

  logic        in_acc;
  logic        out_stall;
  logic [58:0] out_word;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_kind, out_rect_left, out_rect_top, out_rect_right,
                      out_rect_bottom, out_color, out_data_byte, out_last};

  // A stalled word stays put
  `SGTC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word))

  // A character keeps the input closed while its words go out
  `SGTC_ASSERT_NEXT(a_put_busy, in_acc && in_op == OP_PUT_CHAR, !in_ready)

  // Cursor and font commands finish at once
  `SGTC_ASSERT_NEXT(a_quick_ops, in_acc && in_op != OP_PUT_CHAR, in_ready)

  // Only a pixel byte can close a character
  `SGTC_ASSERT_SAME(a_last_on_data, out_valid && out_kind != KIND_DATA, !out_last)

endmodule

bind scaled_glyph_text_cursor sgtc_checker u_sgtc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_rect_left   (out_ch.rect_left),
  .out_rect_top    (out_ch.rect_top),
  .out_rect_right  (out_ch.rect_right),
  .out_rect_bottom (out_ch.rect_bottom),
  .out_color       (out_ch.color),
  .out_data_byte   (out_ch.data_byte),
  .out_last        (out_ch.last)
);
